>>> rtl/core/esc_pkg.sv
package esc_pkg;

    localparam int NUM_FLOORS_DEF = 9;
    localparam int FLOOR_W        = 4;
    localparam int TIMER_W        = 16;
    localparam int PWM_W          = 8;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_CLOSED = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_OPEN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOOR_TICKS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRAVEL_TICKS = 3'd4;

    localparam logic [PWM_W-1:0]   PWM_PERIOD_RST   = 8'd200;
    localparam logic [PWM_W-1:0]   PULSE_CLOSED_RST = 8'd10;
    localparam logic [PWM_W-1:0]   PULSE_OPEN_RST   = 8'd15;
    localparam logic [TIMER_W-1:0] DOOR_TICKS_RST   = 16'd20000;
    localparam logic [TIMER_W-1:0] TRAVEL_TICKS_RST = 16'd10000;

    typedef enum logic [1:0] {
        MOTOR_STOP = 2'd0,
        MOTOR_UP   = 2'd1,
        MOTOR_DOWN = 2'd2
    } motor_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DEPART = 2'd1,
        PH_TRAVEL = 2'd2,
        PH_ARRIVE = 2'd3
    } phase_t;

endpackage

>>> rtl/core/elevator_scan_controller.sv
// elevator scan controller with door servo pwm
// in channel: one item per timer tick, carrying an optional floor call
// (call_valid, call_floor); calls to floors beyond the shaft are dropped.
// out channel: one item per accepted tick with the servo level, motor
// command, car floor, door state, pending call bitmap and direction, all
// as they stand after that tick.
// cfg channel: cfg_index selects pwm_period, pulse_closed, pulse_open,
// door_ticks or travel_ticks; cfg_ready is always high and writes to
// unused indexes are dropped. write only while no tick is in flight.
// the result of a tick is registered into the output buffer.
// throughput: one tick per cycle unless the output buffer is full; the
// whole controller step sits between the state registers and a two-entry
// output buffer. a stalled receiver fills the second output entry, after
// which in_ready drops until the receiver takes an item.
// reset: car at floor 0, heading up, door closed, motor stopped, no calls,
// registers at their defaults, output buffer empty.
module elevator_scan_controller #(
    parameter int NUM_FLOORS = esc_pkg::NUM_FLOORS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           call_valid,
    input  logic [esc_pkg::FLOOR_W-1:0]    call_floor,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           servo_pulse,
    output logic [1:0]                     motor_drive,
    output logic [esc_pkg::FLOOR_W-1:0]    current_floor,
    output logic                           door_open,
    output logic [NUM_FLOORS-1:0]          pending_calls,
    output logic                           going_up,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [esc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int FW   = esc_pkg::FLOOR_W;
    localparam int TW   = esc_pkg::TIMER_W;
    localparam int PW   = esc_pkg::PWM_W;
    localparam int RES_W = 1 + 2 + FW + 1 + NUM_FLOORS + 1;

    // configuration registers
    logic [PW-1:0] pwm_period_reg, pulse_closed_reg, pulse_open_reg;
    logic [TW-1:0] door_ticks_reg, travel_ticks_reg;

    // controller state
    logic [NUM_FLOORS-1:0] calls_reg, calls_next;
    logic                  dir_up_reg, dir_up_next;
    logic [FW-1:0]         floor_reg, floor_next;
    esc_pkg::phase_t       phase_reg, phase_next;
    logic [TW-1:0]         timer_reg, timer_next;
    logic [PW-1:0]         pwm_cnt_reg, pwm_cnt_next;
    logic                  door_reg, door_next;
    esc_pkg::motor_t       motor_reg, motor_next;

    // output buffer
    logic             out_valid_reg, skid_valid_reg;
    logic [RES_W-1:0] out_data_reg, skid_data_reg;
    logic [RES_W-1:0] result;

    logic in_accept;
    logic out_take;

    logic [NUM_FLOORS-1:0] call_onehot, calls_in;
    logic [NUM_FLOORS-1:0] here_onehot, step_onehot;
    logic [NUM_FLOORS-1:0] ge_mask, le_mask;
    logic                  timer_done;
    logic                  at_top, at_bottom, at_end;
    logic [FW-1:0]         step_floor;
    logic                  call_here, call_step;
    logic                  dir_keep_up;
    logic [PW:0]           pwm_inc;
    logic [PW-1:0]         pulse_sel;

    assign in_ready  = !skid_valid_reg;
    assign in_accept = in_valid && in_ready;
    assign out_take  = out_valid_reg && out_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg   <= esc_pkg::PWM_PERIOD_RST;
            pulse_closed_reg <= esc_pkg::PULSE_CLOSED_RST;
            pulse_open_reg   <= esc_pkg::PULSE_OPEN_RST;
            door_ticks_reg   <= esc_pkg::DOOR_TICKS_RST;
            travel_ticks_reg <= esc_pkg::TRAVEL_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                esc_pkg::CFG_PWM_PERIOD:   pwm_period_reg   <= cfg_data[PW-1:0];
                esc_pkg::CFG_PULSE_CLOSED: pulse_closed_reg <= cfg_data[PW-1:0];
                esc_pkg::CFG_PULSE_OPEN:   pulse_open_reg   <= cfg_data[PW-1:0];
                esc_pkg::CFG_DOOR_TICKS:   door_ticks_reg   <= cfg_data[TW-1:0];
                esc_pkg::CFG_TRAVEL_TICKS: travel_ticks_reg <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // floor decodes, built by compare so out-of-range floors match nothing
    always_comb
    begin
        for (int i = 0; i < NUM_FLOORS; i++)
        begin
            call_onehot[i] = (call_floor == FW'(i));
            here_onehot[i] = (floor_reg == FW'(i));
            step_onehot[i] = (step_floor == FW'(i));
            ge_mask[i]     = (FW'(i) >= floor_reg);
            le_mask[i]     = (FW'(i) <= floor_reg);
        end
    end

    assign calls_in   = calls_reg | (call_valid ? call_onehot : '0);
    assign timer_done = (timer_reg <= TW'(1));
    assign at_top     = (floor_reg == FW'(NUM_FLOORS - 1));
    assign at_bottom  = (floor_reg == '0);
    assign at_end     = dir_up_reg ? at_top : at_bottom;
    assign step_floor = at_end ? floor_reg
                      : (dir_up_reg ? floor_reg + FW'(1) : floor_reg - FW'(1));
    assign call_here  = |(calls_in & here_onehot);
    assign call_step  = |(calls_in & step_onehot);
    // keep heading if a call lies at or beyond the car in that direction
    assign dir_keep_up = dir_up_reg ? (|(calls_in & ge_mask))
                                    : !(|(calls_in & le_mask));

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            esc_pkg::PH_IDLE:
                if (|calls_in)
                    phase_next = esc_pkg::PH_DEPART;
            esc_pkg::PH_DEPART:
                if (timer_done)
                    phase_next = call_here ? esc_pkg::PH_ARRIVE : esc_pkg::PH_TRAVEL;
            esc_pkg::PH_TRAVEL:
                if (timer_done && (at_end || call_step))
                    phase_next = esc_pkg::PH_ARRIVE;
            esc_pkg::PH_ARRIVE:
                if (timer_done)
                    phase_next = esc_pkg::PH_IDLE;
            default:
                phase_next = esc_pkg::PH_IDLE;
        endcase
    end

    always_comb
    begin
        calls_next  = calls_in;
        dir_up_next = dir_up_reg;
        floor_next  = floor_reg;
        timer_next  = timer_reg - TW'(1);
        door_next   = door_reg;
        motor_next  = motor_reg;
        unique case (phase_reg)
            esc_pkg::PH_IDLE:
            begin
                timer_next = timer_reg;
                if (|calls_in)
                begin
                    dir_up_next = dir_keep_up;
                    door_next   = 1'b1;
                    timer_next  = door_ticks_reg;
                end
            end
            esc_pkg::PH_DEPART:
                if (timer_done)
                begin
                    if (call_here)
                    begin
                        calls_next = calls_in & ~here_onehot;
                        motor_next = esc_pkg::MOTOR_STOP;
                        door_next  = 1'b1;
                        timer_next = door_ticks_reg;
                    end
                    else
                    begin
                        motor_next = dir_up_reg ? esc_pkg::MOTOR_UP : esc_pkg::MOTOR_DOWN;
                        door_next  = 1'b0;
                        timer_next = travel_ticks_reg;
                    end
                end
            esc_pkg::PH_TRAVEL:
                if (timer_done)
                begin
                    floor_next = step_floor;
                    if (at_end || call_step)
                    begin
                        calls_next = calls_in & ~step_onehot;
                        motor_next = esc_pkg::MOTOR_STOP;
                        door_next  = 1'b1;
                        timer_next = door_ticks_reg;
                    end
                    else
                        timer_next = travel_ticks_reg;
                end
            esc_pkg::PH_ARRIVE:
                if (timer_done)
                begin
                    door_next  = 1'b0;
                    timer_next = '0;
                end
            default: ;
        endcase
    end

    assign pwm_inc      = {1'b0, pwm_cnt_reg} + (PW+1)'(1);
    assign pwm_cnt_next = (pwm_inc >= {1'b0, pwm_period_reg}) ? '0 : pwm_inc[PW-1:0];
    assign pulse_sel    = door_next ? pulse_open_reg : pulse_closed_reg;

    assign result = {pwm_cnt_next < pulse_sel, motor_next, floor_next, door_next,
                     calls_next, dir_up_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calls_reg   <= '0;
            dir_up_reg  <= 1'b1;
            floor_reg   <= '0;
            phase_reg   <= esc_pkg::PH_IDLE;
            timer_reg   <= '0;
            pwm_cnt_reg <= '0;
            door_reg    <= 1'b0;
            motor_reg   <= esc_pkg::MOTOR_STOP;
        end
        else if (in_accept)
        begin
            calls_reg   <= calls_next;
            dir_up_reg  <= dir_up_next;
            floor_reg   <= floor_next;
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            pwm_cnt_reg <= pwm_cnt_next;
            door_reg    <= door_next;
            motor_reg   <= motor_next;
        end
    end

    // two-entry output buffer: skid entry fills only while the head stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || in_accept;
            skid_valid_reg <= 1'b0;
        end
        else if (in_accept)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_take || !out_valid_reg)
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        else if (in_accept)
            skid_data_reg <= result;
    end

    assign out_valid     = out_valid_reg;
    assign servo_pulse   = out_data_reg[RES_W-1];
    assign motor_drive   = out_data_reg[RES_W-2 -: 2];
    assign current_floor = out_data_reg[RES_W-4 -: FW];
    assign door_open     = out_data_reg[NUM_FLOORS+1];
    assign pending_calls = out_data_reg[NUM_FLOORS:1];
    assign going_up      = out_data_reg[0];

endmodule

>>> tb/testbench.sv
module testbench;

    localparam int NUM_FLOORS  = esc_pkg::NUM_FLOORS_DEF;
    localparam int QUIET_LIMIT = 1000;
    // no register lives at this index, the write must be dropped
    localparam logic [esc_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic                        servo;
        logic [1:0]                  motor;
        logic [esc_pkg::FLOOR_W-1:0] floor_no;
        logic                        door;
        logic [NUM_FLOORS-1:0]       calls;
        logic                        up;
    } car_status_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic                            call_valid;
    logic [esc_pkg::FLOOR_W-1:0]     call_floor;
    logic                            out_valid;
    logic                            out_ready;
    logic                            servo_pulse;
    logic [1:0]                      motor_drive;
    logic [esc_pkg::FLOOR_W-1:0]     current_floor;
    logic                            door_open;
    logic [NUM_FLOORS-1:0]           pending_calls;
    logic                            going_up;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [esc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [esc_pkg::CFG_DATA_W-1:0]  cfg_data;

    // predicted car state and register copies
    logic [esc_pkg::PWM_W-1:0]       cfg_period;
    logic [esc_pkg::PWM_W-1:0]       cfg_pulse_closed;
    logic [esc_pkg::PWM_W-1:0]       cfg_pulse_open;
    logic [esc_pkg::TIMER_W-1:0]     cfg_door;
    logic [esc_pkg::TIMER_W-1:0]     cfg_travel;
    logic [NUM_FLOORS-1:0]           car_calls;
    logic                            car_up;
    logic [esc_pkg::FLOOR_W-1:0]     car_at;
    esc_pkg::phase_t                 car_phase;
    logic [esc_pkg::TIMER_W-1:0]     car_timer;
    logic [esc_pkg::PWM_W-1:0]       servo_cnt;
    logic                            car_door;
    esc_pkg::motor_t                 car_motor;

    car_status_t            car_status_q[$];
    int                     mismatches = 0;
    int                     idle_pct;
    int                     quiet_cycles = 0;

    elevator_scan_controller u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .call_valid    (call_valid),
        .call_floor    (call_floor),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .servo_pulse   (servo_pulse),
        .motor_drive   (motor_drive),
        .current_floor (current_floor),
        .door_open     (door_open),
        .pending_calls (pending_calls),
        .going_up      (going_up),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void stop_at_floor();
        car_calls[car_at] = 1'b0;
        car_motor = esc_pkg::MOTOR_STOP;
        car_door = 1'b1;
        car_timer = cfg_door;
        car_phase = esc_pkg::PH_ARRIVE;
    endfunction

    // one timer tick of the controller, returns the status after the tick
    function automatic car_status_t step_car(input logic cv,
                                             input logic [esc_pkg::FLOOR_W-1:0] cf);
        int unsigned here;
        int unsigned above;
        int unsigned below;
        int unsigned cnt;
        logic        at_end;
        car_status_t r;
        here = 32'(car_at);
        if (cv && cf < NUM_FLOORS)
            car_calls[cf] = 1'b1;
        case (car_phase)
            esc_pkg::PH_IDLE:
            begin
                if (car_calls != '0)
                begin
                    // calls at the car's own floor count on both sides
                    above = 32'(car_calls) & ~((32'd1 << here) - 32'd1);
                    below = 32'(car_calls) & ((32'd2 << here) - 32'd1);
                    if (car_up && above == 0)
                        car_up = 1'b0;
                    else if (!car_up && below == 0)
                        car_up = 1'b1;
                    car_door = 1'b1;
                    car_timer = cfg_door;
                    car_phase = esc_pkg::PH_DEPART;
                end
            end
            esc_pkg::PH_DEPART:
            begin
                if (car_timer <= 1)
                begin
                    car_door = 1'b0;
                    if (car_calls[here])
                        stop_at_floor();
                    else
                    begin
                        car_motor = car_up ? esc_pkg::MOTOR_UP : esc_pkg::MOTOR_DOWN;
                        car_timer = cfg_travel;
                        car_phase = esc_pkg::PH_TRAVEL;
                    end
                end
                else
                    car_timer = car_timer - 1'b1;
            end
            esc_pkg::PH_TRAVEL:
            begin
                if (car_timer <= 1)
                begin
                    if (car_up)
                    begin
                        at_end = (here + 1 >= NUM_FLOORS);
                        if (!at_end)
                            here = here + 1;
                    end
                    else
                    begin
                        at_end = (here == 0);
                        if (!at_end)
                            here = here - 1;
                    end
                    car_at = esc_pkg::FLOOR_W'(here);
                    if (at_end || car_calls[here])
                        stop_at_floor();
                    else
                        car_timer = cfg_travel;
                end
                else
                    car_timer = car_timer - 1'b1;
            end
            default:
            begin
                if (car_timer <= 1)
                begin
                    car_door = 1'b0;
                    car_timer = '0;
                    car_phase = esc_pkg::PH_IDLE;
                end
                else
                    car_timer = car_timer - 1'b1;
            end
        endcase
        cnt = 32'(servo_cnt) + 1;
        if (cnt >= cfg_period)
            cnt = 0;
        servo_cnt = esc_pkg::PWM_W'(cnt);
        r.servo = servo_cnt < (car_door ? cfg_pulse_open : cfg_pulse_closed);
        r.motor = car_motor;
        r.floor_no = car_at;
        r.door = car_door;
        r.calls = car_calls;
        r.up = car_up;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t %s expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_status
        car_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (car_status_q.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected item, expected none actual floor %0d",
                         $time, current_floor);
            end
            else
            begin
                want = car_status_q.pop_front();
                check_field("servo_pulse", 16'(want.servo), 16'(servo_pulse));
                check_field("motor_drive", 16'(want.motor), 16'(motor_drive));
                check_field("current_floor", 16'(want.floor_no), 16'(current_floor));
                check_field("door_open", 16'(want.door), 16'(door_open));
                check_field("pending_calls", 16'(want.calls), 16'(pending_calls));
                check_field("going_up", 16'(want.up), 16'(going_up));
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3 + 1)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_tick(input logic cv, input logic [esc_pkg::FLOOR_W-1:0] cf);
        int gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 12);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        call_valid <= cv;
        call_floor <= cf;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        car_status_q.push_back(step_car(cv, cf));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (car_status_q.size() != 0)
            @(posedge clk);
        // results are registered, leave some margin
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [esc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [esc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            esc_pkg::CFG_PWM_PERIOD:   cfg_period = data[esc_pkg::PWM_W-1:0];
            esc_pkg::CFG_PULSE_CLOSED: cfg_pulse_closed = data[esc_pkg::PWM_W-1:0];
            esc_pkg::CFG_PULSE_OPEN:   cfg_pulse_open = data[esc_pkg::PWM_W-1:0];
            esc_pkg::CFG_DOOR_TICKS:   cfg_door = data;
            esc_pkg::CFG_TRAVEL_TICKS: cfg_travel = data;
            default:                   ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // 8-bit registers get junk in the upper byte, it must be dropped
    task automatic program_regs(input logic [7:0] period, input logic [7:0] closed,
                                input logic [7:0] opened, input logic [15:0] door,
                                input logic [15:0] travel);
        drain_results();
        write_reg(esc_pkg::CFG_PWM_PERIOD, {8'($urandom), period});
        write_reg(esc_pkg::CFG_PULSE_CLOSED, {8'($urandom), closed});
        write_reg(esc_pkg::CFG_PULSE_OPEN, {8'($urandom), opened});
        write_reg(esc_pkg::CFG_DOOR_TICKS, door);
        write_reg(esc_pkg::CFG_TRAVEL_TICKS, travel);
    endtask

    task automatic test_reset_defaults();
        idle_pct = 0;
        repeat (3) send_tick(1'b0, 4'd0);
    endtask

    // zero timers act as one tick, pwm period zero holds the counter
    task automatic test_far_call();
        program_regs(8'd0, 8'd255, 8'd0, 16'd0, 16'd0);
        write_reg(CFG_UNUSED, 16'hffff);
        idle_pct = 30;
        send_tick(1'b1, 4'd8);
        repeat (10) send_tick(1'b0, 4'($urandom));
    endtask

    // car idle at floor 8: door opens once, motor stays stopped
    task automatic test_call_at_car();
        send_tick(1'b1, 4'd8);
        repeat (3) send_tick(1'b0, 4'($urandom));
    endtask

    task automatic test_missing_floor();
        send_tick(1'b1, 4'd9);
        send_tick(1'b1, 4'd15);
        send_tick(1'b0, 4'd15);
    endtask

    task automatic test_random_service(input int ticks, input int pct);
        logic                        cv;
        logic [esc_pkg::FLOOR_W-1:0] cf;
        idle_pct = pct;
        repeat (ticks)
        begin
            cv = ($urandom_range(0, 99) < 25);
            if ($urandom_range(0, 9) == 0)
                cf = esc_pkg::FLOOR_W'($urandom_range(NUM_FLOORS, 15));
            else
                cf = esc_pkg::FLOOR_W'($urandom_range(0, NUM_FLOORS - 1));
            send_tick(cv, cf);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        call_valid = 1'b0;
        call_floor = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        cfg_period = esc_pkg::PWM_PERIOD_RST;
        cfg_pulse_closed = esc_pkg::PULSE_CLOSED_RST;
        cfg_pulse_open = esc_pkg::PULSE_OPEN_RST;
        cfg_door = esc_pkg::DOOR_TICKS_RST;
        cfg_travel = esc_pkg::TRAVEL_TICKS_RST;
        car_calls = '0;
        car_up = 1'b1;
        car_at = '0;
        car_phase = esc_pkg::PH_IDLE;
        car_timer = '0;
        servo_cnt = '0;
        car_door = 1'b0;
        car_motor = esc_pkg::MOTOR_STOP;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_far_call();
        test_call_at_car();
        test_missing_floor();

        program_regs(8'($urandom_range(2, 255)), 8'($urandom), 8'($urandom),
                     16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)));
        test_random_service(80, 20);
        program_regs(8'd255, 8'd0, 8'd255, 16'd1, 16'd1);
        test_random_service(80, 30);
        program_regs(8'd2, 8'd1, 8'd2, 16'd3, 16'd2);
        test_random_service(80, 0);
        program_regs(8'd1, 8'($urandom), 8'($urandom), 16'd2, 16'd4);
        test_random_service(80, 40);
        program_regs(8'($urandom_range(2, 40)), 8'($urandom_range(0, 40)),
                     8'($urandom_range(0, 40)), 16'($urandom_range(1, 6)),
                     16'($urandom_range(1, 5)));
        test_random_service(80, 15);
        // long timers last, the car stays in whatever step it enters
        program_regs(8'd255, 8'd255, 8'd128, 16'd65535, 16'd65535);
        test_random_service(40, 0);

        drain_results();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
